FILE: design/lswc_pkg.sv
// Shared types and constants for the line segment window clipper.
// No dependencies; imported by the boundary stage and the top level.
`default_nettype none

package lswc_pkg;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// window register index, byte address is 4*index
	typedef enum logic [1:0] {
		REG_WINDOW_LEFT   = 2'd0,
		REG_WINDOW_BOTTOM = 2'd1,
		REG_WINDOW_RIGHT  = 2'd2,
		REG_WINDOW_TOP    = 2'd3
	} reg_idx_t;

	// window edge handled by one boundary stage, in test order
	typedef enum logic [1:0] {
		BND_LEFT   = 2'd0,
		BND_RIGHT  = 2'd1,
		BND_BOTTOM = 2'd2,
		BND_TOP    = 2'd3
	} bnd_t;

	// control that travels with every beat down the pipe
	typedef struct packed {
		logic valid;
		logic ok;
	} lswc_ctl_t;

endpackage

`default_nettype wire

FILE: design/line_segment_window_clipper.sv
// Top level of the line segment window clipper: window registers, input stage,
// four lswc_boundary stages, scale multipliers, lswc_divider lanes, output stage.
// Uses lswc_pkg.
//
//  channel  signals                                          role
//  seg      seg_valid/seg_ready, start_x start_y end_x end_y  segment in
//  res      res_valid/res_ready, visible clipped_*            clipped result out
//  apb      psel penable pwrite paddr pwdata prdata pready    window registers
//
// One segment per cycle while no result waits unaccepted. The registers, in order:
// input stage, two per edge, multiply, one per quotient bit in the dividers,
// output register. The whole pipe holds while a result waits unaccepted;
// seg_ready is low exactly then. Reset clears valid bits and sets the window
// to its defaults.
`default_nettype none

module line_segment_window_clipper
	import lswc_pkg::*;
#(
	parameter int COORD_WIDTH   = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  seg_valid,
	output logic                                  seg_ready,
	input  logic signed [COORD_WIDTH-1:0]         start_x,
	input  logic signed [COORD_WIDTH-1:0]         start_y,
	input  logic signed [COORD_WIDTH-1:0]         end_x,
	input  logic signed [COORD_WIDTH-1:0]         end_y,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic                                  visible,
	output logic signed [COORD_WIDTH+FRACTION_BITS-1:0] clipped_start_x,
	output logic signed [COORD_WIDTH+FRACTION_BITS-1:0] clipped_start_y,
	output logic signed [COORD_WIDTH+FRACTION_BITS-1:0] clipped_end_x,
	output logic signed [COORD_WIDTH+FRACTION_BITS-1:0] clipped_end_y,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [APB_ADDR_W-1:0]                 paddr,
	input  logic [APB_DATA_W-1:0]                 pwdata,
	output logic [APB_DATA_W-1:0]                 prdata,
	output logic                                  pready
);

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int OW = W + F;
	localparam int DW = 2 * W + F;

	// ---------------- window registers ----------------
	logic signed [W-1:0] win_left_q, win_bottom_q, win_right_q, win_top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= '0;
			win_bottom_q <= '0;
			win_right_q  <= W'(255);
			win_top_q    <= W'(255);
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_WINDOW_LEFT:   win_left_q   <= pwdata[W-1:0];
				REG_WINDOW_BOTTOM: win_bottom_q <= pwdata[W-1:0];
				REG_WINDOW_RIGHT:  win_right_q  <= pwdata[W-1:0];
				REG_WINDOW_TOP:    win_top_q    <= pwdata[W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_WINDOW_LEFT:   prdata = APB_DATA_W'(win_left_q);
			REG_WINDOW_BOTTOM: prdata = APB_DATA_W'(win_bottom_q);
			REG_WINDOW_RIGHT:  prdata = APB_DATA_W'(win_right_q);
			REG_WINDOW_TOP:    prdata = APB_DATA_W'(win_top_q);
		endcase
	end

	assign pready = 1'b1;

	// ---------------- pipe advance ----------------
	logic adv;
	assign adv       = !res_valid || res_ready;
	assign seg_ready = adv;

	// ---------------- input stage ----------------
	lswc_ctl_t           ctl_s1;
	logic signed [W-1:0] x0_s1, y0_s1;
	logic signed [W:0]   dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= seg_valid;
			ctl_s1.ok    <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s1 <= start_x;
			y0_s1 <= start_y;
			dx_s1 <= (W+1)'(end_x) - (W+1)'(start_x);
			dy_s1 <= (W+1)'(end_y) - (W+1)'(start_y);
		end
	end

	// ---------------- edge tests ----------------
	lswc_ctl_t           ctl_b  [5];
	logic signed [W-1:0] x0_b   [5];
	logic signed [W-1:0] y0_b   [5];
	logic signed [W:0]   dx_b   [5];
	logic signed [W:0]   dy_b   [5];
	logic signed [W:0]   en_n_b [5];
	logic signed [W:0]   en_d_b [5];
	logic signed [W:0]   ex_n_b [5];
	logic signed [W:0]   ex_d_b [5];
	logic signed [W-1:0] win_sel [4];

	// entry starts at 0/1, exit at 1/1
	assign ctl_b[0]  = ctl_s1;
	assign x0_b[0]   = x0_s1;
	assign y0_b[0]   = y0_s1;
	assign dx_b[0]   = dx_s1;
	assign dy_b[0]   = dy_s1;
	assign en_n_b[0] = '0;
	assign en_d_b[0] = (W+1)'(1);
	assign ex_n_b[0] = (W+1)'(1);
	assign ex_d_b[0] = (W+1)'(1);

	assign win_sel[0] = win_left_q;
	assign win_sel[1] = win_right_q;
	assign win_sel[2] = win_bottom_q;
	assign win_sel[3] = win_top_q;

	for (genvar i = 0; i < 4; i++) begin : g_edge
		lswc_boundary #(
			.W    (W),
			.SIDE (bnd_t'(i))
		) u_boundary (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctl_in   (ctl_b[i]),
			.x0_in    (x0_b[i]),
			.y0_in    (y0_b[i]),
			.win      (win_sel[i]),
			.dx_in    (dx_b[i]),
			.dy_in    (dy_b[i]),
			.en_n_in  (en_n_b[i]),
			.en_d_in  (en_d_b[i]),
			.ex_n_in  (ex_n_b[i]),
			.ex_d_in  (ex_d_b[i]),
			.ctl_out  (ctl_b[i+1]),
			.x0_out   (x0_b[i+1]),
			.y0_out   (y0_b[i+1]),
			.dx_out   (dx_b[i+1]),
			.dy_out   (dy_b[i+1]),
			.en_n_out (en_n_b[i+1]),
			.en_d_out (en_d_b[i+1]),
			.ex_n_out (ex_n_b[i+1]),
			.ex_d_out (ex_d_b[i+1])
		);
	end

	// ---------------- multiply, divide, rebuild ----------------
	// lanes: start x, start y, end x, end y
	lswc_ctl_t        ctl_s10;
	logic signed [OW-1:0] res_c [4];
	logic             ok_c  [4];
	logic             vld_c [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s10 <= '0;
		end else if (adv) begin
			ctl_s10 <= ctl_b[4];
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		localparam bit IS_Y  = (l % 2) == 1;
		localparam bit IS_EX = l >= 2;
		localparam int QW_C  = OW;

		logic signed [W:0]   delta, delta_neg, frac_n, frac_d;
		logic signed [W-1:0] base;
		logic [W-1:0]        dmag;
		logic [2*W-1:0]      m_s10;
		logic [W-1:0]        den_s10;
		logic signed [W-1:0] base_s10;
		logic                neg_s10;
		logic [DW-1:0]       num_w;
		logic [QW_C-1:0]     quo;
		logic                rem_nz;
		logic [W+1:0]        sb_out;
		logic signed [OW-1:0] base_w, off;

		assign delta     = IS_Y ? dy_b[4] : dx_b[4];
		assign base      = IS_Y ? y0_b[4] : x0_b[4];
		assign frac_n    = IS_EX ? ex_n_b[4] : en_n_b[4];
		assign frac_d    = IS_EX ? ex_d_b[4] : en_d_b[4];
		assign delta_neg = -delta;
		assign dmag      = delta[W] ? delta_neg[W-1:0] : delta[W-1:0];

		always_ff @(posedge clk) begin
			if (adv) begin
				m_s10    <= (2*W)'(dmag) * (2*W)'(frac_n[W-1:0]);
				den_s10  <= frac_d[W-1:0];
				base_s10 <= base;
				neg_s10  <= delta[W];
			end
		end

		assign num_w = DW'(m_s10) << F;

		lswc_divider #(
			.NW  (DW),
			.DVW (W),
			.QW  (QW_C),
			.SBW (W + 2)
		) u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (ctl_s10.valid),
			.num     (num_w),
			.den     (den_s10),
			.sb_in   ({ctl_s10.ok, base_s10, neg_s10}),
			.vld_out (vld_c[l]),
			.quo     (quo),
			.rem_nz  (rem_nz),
			.sb_out  (sb_out)
		);

		// floor of a negative offset rounds away when a remainder is left
		assign base_w   = OW'($signed(sb_out[W:1])) <<< F;
		assign off      = sb_out[0] ? (-$signed(quo) - OW'(rem_nz)) : $signed(quo);
		assign res_c[l] = base_w + off;
		assign ok_c[l]  = sb_out[W+1];
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= vld_c[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			visible         <= ok_c[0];
			clipped_start_x <= ok_c[0] ? res_c[0] : '0;
			clipped_start_y <= ok_c[1] ? res_c[1] : '0;
			clipped_end_x   <= ok_c[2] ? res_c[2] : '0;
			clipped_end_y   <= ok_c[3] ? res_c[3] : '0;
		end
	end

endmodule

`default_nettype wire

FILE: design/lswc_boundary.sv
// One window edge test of the clipper: two register stages
// (cross products, then compare and update of entry/exit). Uses lswc_pkg.
`default_nettype none

module lswc_boundary
	import lswc_pkg::*;
#(
	parameter int   W    = 16,
	parameter bnd_t SIDE = BND_LEFT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  lswc_ctl_t           ctl_in,
	input  logic signed [W-1:0] x0_in,
	input  logic signed [W-1:0] y0_in,
	input  logic signed [W-1:0] win,
	input  logic signed [W:0]   dx_in,
	input  logic signed [W:0]   dy_in,
	input  logic signed [W:0]   en_n_in,
	input  logic signed [W:0]   en_d_in,
	input  logic signed [W:0]   ex_n_in,
	input  logic signed [W:0]   ex_d_in,
	output lswc_ctl_t           ctl_out,
	output logic signed [W-1:0] x0_out,
	output logic signed [W-1:0] y0_out,
	output logic signed [W:0]   dx_out,
	output logic signed [W:0]   dy_out,
	output logic signed [W:0]   en_n_out,
	output logic signed [W:0]   en_d_out,
	output logic signed [W:0]   ex_n_out,
	output logic signed [W:0]   ex_d_out
);

	localparam int PW = 2 * W + 2;

	logic signed [W:0] p, q, rn, rd;

	always_comb begin
		unique case (SIDE)
			BND_LEFT: begin
				p = -dx_in;
				q = (W+1)'(x0_in) - (W+1)'(win);
			end
			BND_RIGHT: begin
				p = dx_in;
				q = (W+1)'(win) - (W+1)'(x0_in);
			end
			BND_BOTTOM: begin
				p = -dy_in;
				q = (W+1)'(y0_in) - (W+1)'(win);
			end
			BND_TOP: begin
				p = dy_in;
				q = (W+1)'(win) - (W+1)'(y0_in);
			end
		endcase
		// ratio q/p with a non-negative denominator
		rn = p[W] ? -q : q;
		rd = p[W] ? -p : p;
	end

	lswc_ctl_t          ctl_s1;
	logic signed [W-1:0] x0_s1, y0_s1;
	logic signed [W:0]   dx_s1, dy_s1, en_n_s1, en_d_s1, ex_n_s1, ex_d_s1, rn_s1, rd_s1;
	logic                pzero_s1, pneg_s1, qneg_s1;
	logic signed [PW-1:0] pen_r_s1, pen_e_s1, pex_r_s1, pex_e_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s1    <= x0_in;
			y0_s1    <= y0_in;
			dx_s1    <= dx_in;
			dy_s1    <= dy_in;
			en_n_s1  <= en_n_in;
			en_d_s1  <= en_d_in;
			ex_n_s1  <= ex_n_in;
			ex_d_s1  <= ex_d_in;
			rn_s1    <= rn;
			rd_s1    <= rd;
			pzero_s1 <= (p == '0);
			pneg_s1  <= p[W];
			qneg_s1  <= q[W];
			pen_r_s1 <= PW'(rn) * PW'(en_d_in);
			pen_e_s1 <= PW'(en_n_in) * PW'(rd);
			pex_r_s1 <= PW'(rn) * PW'(ex_d_in);
			pex_e_s1 <= PW'(ex_n_in) * PW'(rd);
		end
	end

	logic ok_nxt, upd_en, upd_ex;

	always_comb begin
		ok_nxt = ctl_s1.ok;
		upd_en = 1'b0;
		upd_ex = 1'b0;
		if (ctl_s1.ok) begin
			if (pzero_s1) begin
				ok_nxt = !qneg_s1;
			end else if (pneg_s1) begin
				// entering edge: past the exit rejects, else raise entry
				if (pex_r_s1 > pex_e_s1) ok_nxt = 1'b0;
				else upd_en = (pen_r_s1 > pen_e_s1);
			end else begin
				// leaving edge: before the entry rejects, else lower exit
				if (pen_r_s1 < pen_e_s1) ok_nxt = 1'b0;
				else upd_ex = (pex_r_s1 < pex_e_s1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (adv) begin
			ctl_out.valid <= ctl_s1.valid;
			ctl_out.ok    <= ok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_out   <= x0_s1;
			y0_out   <= y0_s1;
			dx_out   <= dx_s1;
			dy_out   <= dy_s1;
			en_n_out <= upd_en ? rn_s1 : en_n_s1;
			en_d_out <= upd_en ? rd_s1 : en_d_s1;
			ex_n_out <= upd_ex ? rn_s1 : ex_n_s1;
			ex_d_out <= upd_ex ? rd_s1 : ex_d_s1;
		end
	end

endmodule

`default_nettype wire

FILE: design/lswc_divider.sv
// Pipelined restoring divider, one quotient bit per register stage,
// with a sideband that travels alongside. No dependencies.
`default_nettype none

module lswc_divider #(
	parameter int NW  = 40,
	parameter int DVW = 16,
	parameter int QW  = 24,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           vld_in,
	input  logic [NW-1:0]  num,
	input  logic [DVW-1:0] den,
	input  logic [SBW-1:0] sb_in,
	output logic           vld_out,
	output logic [QW-1:0]  quo,
	output logic           rem_nz,
	output logic [SBW-1:0] sb_out
);

	// the caller guarantees num >> QW < den, so the top bits seed the remainder
	logic [DVW-1:0] rem_s [1:QW];
	logic [QW-1:0]  low_s [1:QW];
	logic [QW-1:0]  quo_s [1:QW];
	logic [DVW-1:0] den_s [1:QW];
	logic [SBW-1:0] sb_s  [1:QW];
	logic           vld_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DVW-1:0] src_rem, src_den;
		logic [QW-1:0]  src_low, src_quo;
		logic [SBW-1:0] src_sb;
		logic           src_vld;
		logic [DVW:0]   r2, diff;
		logic           ge;

		if (k == 0) begin : g_first
			assign src_rem = DVW'(num[NW-1:QW]);
			assign src_low = num[QW-1:0];
			assign src_quo = '0;
			assign src_den = den;
			assign src_sb  = sb_in;
			assign src_vld = vld_in;
		end else begin : g_next
			assign src_rem = rem_s[k];
			assign src_low = low_s[k];
			assign src_quo = quo_s[k];
			assign src_den = den_s[k];
			assign src_sb  = sb_s[k];
			assign src_vld = vld_s[k];
		end

		assign r2   = {src_rem, src_low[QW-1]};
		assign diff = r2 - {1'b0, src_den};
		assign ge   = (r2 >= {1'b0, src_den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? diff[DVW-1:0] : r2[DVW-1:0];
				low_s[k+1] <= src_low << 1;
				quo_s[k+1] <= {src_quo[QW-2:0], ge};
				den_s[k+1] <= src_den;
				sb_s[k+1]  <= src_sb;
			end
		end
	end

	assign vld_out = vld_s[QW];
	assign quo     = quo_s[QW];
	assign rem_nz  = (rem_s[QW] != '0);
	assign sb_out  = sb_s[QW];

endmodule

`default_nettype wire
